// File: rtl/core/ipf_pkg.sv
// shared constants and types for the ipv4 packet filter
package ipf_pkg;

  localparam int WhitelistDepthDef = 16;
  localparam int BlacklistDepthDef = 64;
  localparam int CounterBitsDef    = 48;

  localparam logic [1:0] CmdByte   = 2'd0;
  localparam logic [1:0] CmdWrWl   = 2'd1;
  localparam logic [1:0] CmdWrBl   = 2'd2;
  localparam logic [1:0] CmdRdCnt  = 2'd3;

  localparam logic [3:0] RsnShort   = 4'd0;
  localparam logic [3:0] RsnNonIp   = 4'd1;
  localparam logic [3:0] RsnWhite   = 4'd2;
  localparam logic [3:0] RsnClean   = 4'd3;
  localparam logic [3:0] RsnBadIp   = 4'd4;
  localparam logic [3:0] RsnBlack   = 4'd5;
  localparam logic [3:0] RsnTrunc   = 4'd6;
  localparam logic [3:0] RsnSynFin  = 4'd7;
  localparam logic [3:0] RsnSynRst  = 4'd8;
  localparam logic [3:0] RsnNull    = 4'd9;
  localparam logic [3:0] RsnUdpAmp  = 4'd10;
  localparam logic [3:0] RsnRedir   = 4'd11;
  localparam logic [3:0] RsnIcmpBig = 4'd12;

  localparam logic [2:0] CntTotal = 3'd0;
  localparam logic [2:0] CntDrop  = 3'd1;
  localparam logic [2:0] CntPass  = 3'd2;
  localparam logic [2:0] CntSyn   = 3'd3;
  localparam logic [2:0] CntUdp   = 3'd4;
  localparam logic [2:0] CntIcmp  = 3'd5;
  localparam int NumCounters = 6;

  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [7:0]  ProtoIcmp = 8'd1;
  localparam logic [15:0] PortDns   = 16'd53;
  localparam logic [15:0] PortNtp   = 16'd123;
  localparam logic [15:0] PortSsdp  = 16'd1900;
  localparam logic [15:0] PortMemc  = 16'd11211;
  localparam logic [15:0] UdpLimitRst  = 16'd512;
  localparam logic [15:0] IcmpLimitRst = 16'd1500;

  localparam logic [0:0] CfgUdpLimit  = 1'b0;
  localparam logic [0:0] CfgIcmpLimit = 1'b1;

  // lookup or list write walking the cam cell chain
  typedef struct packed {
    logic        vld;
    logic        wr;
    logic [5:0]  slot;
    logic        wr_valid;
    logic [31:0] addr;
    logic        hit;
  } cam_probe_t;

  // parsed frame summary handed to the verdict stage
  typedef struct packed {
    logic [6:0]  pos;
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] l4_first_word;
    logic [15:0] udp_length_field;
    logic [5:0]  tcp_flag_bits;
  } frame_sum_t;

endpackage

// File: rtl/core/ipf_if.sv
// valid/ready channel interfaces
interface ipf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  pkt_byte;
  logic        end_of_packet;
  logic [5:0]  slot;
  logic [31:0] entry_address;
  logic        entry_valid;
  logic [2:0]  counter_select;
  modport source (output valid, cmd, pkt_byte, end_of_packet, slot, entry_address,
                  entry_valid, counter_select, input ready);
  modport sink (input valid, cmd, pkt_byte, end_of_packet, slot, entry_address,
                entry_valid, counter_select, output ready);
endinterface

interface ipf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        verdict;
  logic [3:0]  reason;
  logic [47:0] counter_value;
  modport source (output valid, result_kind, verdict, reason, counter_value,
                  input ready);
  modport sink (input valid, result_kind, verdict, reason, counter_value,
                output ready);
endinterface

interface ipf_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/ipf_cam_cell.sv
// one list entry: stores an address and matches the probe passing through
module ipf_cam_cell
  import ipf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        adv,
  input  cam_probe_t  probe_in,
  output cam_probe_t  probe_out
);
  logic        entry_vld;
  logic [31:0] entry_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else if (wr_en) begin
      entry_vld <= probe_in.wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_addr <= probe_in.addr;
    end
  end

  // probe moves one cell per advancing cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.vld <= 1'b0;
      probe_out.wr  <= 1'b0;
    end else if (adv) begin
      probe_out.vld <= probe_in.vld;
      probe_out.wr  <= probe_in.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      probe_out.slot     <= probe_in.slot;
      probe_out.wr_valid <= probe_in.wr_valid;
      probe_out.addr     <= probe_in.addr;
      probe_out.hit      <= probe_in.hit | (entry_vld & (entry_addr == probe_in.addr));
    end
  end
endmodule

// File: rtl/core/ipf_cam_chain.sv
// row of cam cells, probes and list writes ripple from the first to the last
module ipf_cam_chain
  import ipf_pkg::*;
#(
  parameter int Depth = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  cam_probe_t  probe_in,
  output cam_probe_t  probe_out
);
  cam_probe_t link [Depth+1];

  assign link[0]   = probe_in;
  assign probe_out = link[Depth];

  // a write lands in its cell as it passes, so it never overtakes an older probe
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    ipf_cam_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (adv && link[g].wr && ({26'd0, link[g].slot} == 32'(g))),
      .adv      (adv),
      .probe_in (link[g]),
      .probe_out(link[g+1])
    );
  end
endmodule

// File: rtl/core/ipf_parser.sv
// byte-serial header parser
module ipf_parser
  import ipf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic [7:0] pkt_byte,
  input  logic       eop,
  output frame_sum_t sum
);
  frame_sum_t st;
  frame_sum_t cur;
  frame_sum_t st_next;
  logic [6:0] l4;
  logic [6:0] off;

  always_comb begin
    cur = st;
    l4  = 7'd14 + {1'b0, st.header_words, 2'b00};
    off = st.pos - l4;
    case (st.pos)
      7'd12:   cur.ether_kind = {pkt_byte, 8'd0};
      7'd13:   cur.ether_kind = {st.ether_kind[15:8], pkt_byte};
      7'd14:   cur.header_words = pkt_byte[3:0];
      7'd16:   cur.ip_total_length = {pkt_byte, 8'd0};
      7'd17:   cur.ip_total_length = {st.ip_total_length[15:8], pkt_byte};
      7'd23:   cur.ip_protocol = pkt_byte;
      7'd26, 7'd27, 7'd28, 7'd29:
               cur.source_address = {st.source_address[23:0], pkt_byte};
      default: ;
    endcase
    if (st.pos > 7'd14 && st.pos < 7'd127 && st.pos >= l4) begin
      case (off)
        7'd0:    cur.l4_first_word = {pkt_byte, 8'd0};
        7'd1:    cur.l4_first_word = {st.l4_first_word[15:8], pkt_byte};
        7'd4:    cur.udp_length_field = {pkt_byte, 8'd0};
        7'd5:    cur.udp_length_field = {st.udp_length_field[15:8], pkt_byte};
        7'd13:   cur.tcp_flag_bits = pkt_byte[5:0];
        default: ;
      endcase
    end
    st_next     = cur;
    st_next.pos = (st.pos == 7'd127) ? st.pos : st.pos + 7'd1;
  end

  assign sum = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (byte_en) begin
      if (eop) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end
endmodule

// File: rtl/core/ipv4_packet_filter_unit.sv
// top level of the ipv4 packet filter
// a verdict leaves through the job delay line and the output register once the last byte
//   is taken, the cam probe walks one cell per advancing cycle; counter reads take the same path
// throughput: one beat per cycle, a new beat is taken every cycle the pipe advances
// the whole pipe stalls only while the output register is full and not taken
// reset (rst, synchronous): lists empty, counters zero, limits 512 and 1500
module ipv4_packet_filter_unit
  import ipf_pkg::*;
#(
  parameter int WHITELIST_DEPTH = WhitelistDepthDef,
  parameter int BLACKLIST_DEPTH = BlacklistDepthDef,
  parameter int COUNTER_BITS    = CounterBitsDef
) (
  input logic clk,
  input logic rst,
  ipf_in_if.sink    in_ch,
  ipf_cfg_if.sink   cfg,
  ipf_out_if.source out_ch
);
  localparam int ChainLen = (WHITELIST_DEPTH > BLACKLIST_DEPTH) ?
                            WHITELIST_DEPTH : BLACKLIST_DEPTH;

  // pipe advances whenever the output slot is free or being emptied
  logic adv;
  logic in_fire;
  assign adv       = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire   = in_ch.valid && adv;
  assign cfg.ready = 1'b1;

  logic [15:0] udp_limit;
  logic [15:0] icmp_limit;
  always_ff @(posedge clk) begin
    if (rst) begin
      udp_limit  <= UdpLimitRst;
      icmp_limit <= IcmpLimitRst;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgUdpLimit:  udp_limit  <= cfg.data;
        CfgIcmpLimit: icmp_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // parser sees every frame byte
  frame_sum_t sum;
  ipf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .byte_en (in_fire && in_ch.cmd == CmdByte),
    .pkt_byte(in_ch.pkt_byte),
    .eop     (in_ch.end_of_packet),
    .sum     (sum)
  );

  // job travelling alongside the cam probes: frame end or counter read
  typedef struct packed {
    logic       vld;
    logic       is_rd;
    logic [2:0] sel;
    frame_sum_t fs;
  } job_t;

  job_t job_in;
  assign job_in.vld   = in_fire && ((in_ch.cmd == CmdByte && in_ch.end_of_packet) ||
                                    in_ch.cmd == CmdRdCnt);
  assign job_in.is_rd = in_ch.cmd == CmdRdCnt;
  assign job_in.sel   = in_ch.counter_select;
  assign job_in.fs    = sum;

  // list writes walk the chain in beat order with the probes: a probe taken earlier
  // stays ahead and sees old contents, a later one trails and sees the new entry
  cam_probe_t wl_in, wl_out, bl_in, bl_out;
  assign wl_in.vld      = job_in.vld;
  assign wl_in.wr       = in_fire && in_ch.cmd == CmdWrWl;
  assign wl_in.slot     = in_ch.slot;
  assign wl_in.wr_valid = in_ch.entry_valid;
  assign wl_in.addr     = (in_ch.cmd == CmdByte) ? sum.source_address : in_ch.entry_address;
  assign wl_in.hit      = 1'b0;
  assign bl_in.vld      = job_in.vld;
  assign bl_in.wr       = in_fire && in_ch.cmd == CmdWrBl;
  assign bl_in.slot     = in_ch.slot;
  assign bl_in.wr_valid = in_ch.entry_valid;
  assign bl_in.addr     = (in_ch.cmd == CmdByte) ? sum.source_address : in_ch.entry_address;
  assign bl_in.hit      = 1'b0;

  ipf_cam_chain #(.Depth(WHITELIST_DEPTH)) u_wl (
    .clk(clk), .rst(rst),
    .adv(adv), .probe_in(wl_in), .probe_out(wl_out)
  );
  ipf_cam_chain #(.Depth(BLACKLIST_DEPTH)) u_bl (
    .clk(clk), .rst(rst),
    .adv(adv), .probe_in(bl_in), .probe_out(bl_out)
  );

  // delay lines so both hit flags and the job line up at the end of the longer chain
  job_t job_pipe [ChainLen+1];
  logic wl_hit_pipe [ChainLen-WHITELIST_DEPTH+1];
  logic bl_hit_pipe [ChainLen-BLACKLIST_DEPTH+1];
  assign job_pipe[0]    = job_in;
  assign wl_hit_pipe[0] = wl_out.hit;
  assign bl_hit_pipe[0] = bl_out.hit;

  for (genvar g = 0; g < ChainLen; g++) begin : g_job
    always_ff @(posedge clk) begin
      if (rst) begin
        job_pipe[g+1].vld <= 1'b0;
      end else if (adv) begin
        job_pipe[g+1].vld <= job_pipe[g].vld;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        job_pipe[g+1].is_rd <= job_pipe[g].is_rd;
        job_pipe[g+1].sel   <= job_pipe[g].sel;
        job_pipe[g+1].fs    <= job_pipe[g].fs;
      end
    end
  end
  for (genvar g = 0; g < ChainLen - WHITELIST_DEPTH; g++) begin : g_wld
    always_ff @(posedge clk) begin
      if (adv) wl_hit_pipe[g+1] <= wl_hit_pipe[g];
    end
  end
  for (genvar g = 0; g < ChainLen - BLACKLIST_DEPTH; g++) begin : g_bld
    always_ff @(posedge clk) begin
      if (adv) bl_hit_pipe[g+1] <= bl_hit_pipe[g];
    end
  end

  job_t       jb;
  frame_sum_t f;
  logic       wl_hit, bl_hit;
  assign jb     = job_pipe[ChainLen];
  assign f      = jb.fs;
  assign wl_hit = wl_hit_pipe[ChainLen-WHITELIST_DEPTH];
  assign bl_hit = bl_hit_pipe[ChainLen-BLACKLIST_DEPTH];

  // verdict logic
  logic [7:0]  len;
  logic [7:0]  l4;
  logic [15:0] payload;
  logic        drop;
  logic [3:0]  rsn;
  logic        bump_syn, bump_udp, bump_icmp;
  logic        refl_port;

  always_comb begin
    len       = {1'b0, f.pos} + 8'd1;
    l4        = 8'd14 + {2'b00, f.header_words, 2'b00};
    payload   = f.udp_length_field - 16'd8;
    refl_port = f.l4_first_word == PortDns || f.l4_first_word == PortNtp ||
                f.l4_first_word == PortSsdp || f.l4_first_word == PortMemc;
    drop      = 1'b0;
    rsn       = RsnClean;
    bump_syn  = 1'b0;
    bump_udp  = 1'b0;
    bump_icmp = 1'b0;
    if (len < 8'd14) begin
      rsn = RsnShort;
    end else if (f.ether_kind != EtherIpv4) begin
      rsn = RsnNonIp;
    end else if (len < 8'd34 || f.header_words < 4'd5) begin
      drop = 1'b1; rsn = RsnBadIp;
    end else if (wl_hit) begin
      rsn = RsnWhite;
    end else if (bl_hit) begin
      drop = 1'b1; rsn = RsnBlack;
    end else if (f.ip_protocol == ProtoTcp) begin
      if ({1'b0, len} < {1'b0, l4} + 9'd20) begin
        drop = 1'b1; rsn = RsnTrunc;
      end else begin
        bump_syn = f.tcp_flag_bits[1] && !f.tcp_flag_bits[4];
        if (f.tcp_flag_bits[1:0] == 2'b11) begin
          drop = 1'b1; rsn = RsnSynFin;
        end else if (f.tcp_flag_bits[2:1] == 2'b11) begin
          drop = 1'b1; rsn = RsnSynRst;
        end else if (f.tcp_flag_bits == 6'd0) begin
          drop = 1'b1; rsn = RsnNull;
        end
      end
    end else if (f.ip_protocol == ProtoUdp) begin
      if ({1'b0, len} < {1'b0, l4} + 9'd8) begin
        drop = 1'b1; rsn = RsnTrunc;
      end else begin
        bump_udp = 1'b1;
        if (refl_port && payload > udp_limit) begin
          drop = 1'b1; rsn = RsnUdpAmp;
        end
      end
    end else if (f.ip_protocol == ProtoIcmp) begin
      if ({1'b0, len} < {1'b0, l4} + 9'd8) begin
        drop = 1'b1; rsn = RsnTrunc;
      end else begin
        bump_icmp = 1'b1;
        if (f.l4_first_word[15:8] == 8'd5) begin
          drop = 1'b1; rsn = RsnRedir;
        end else if (f.ip_total_length > icmp_limit) begin
          drop = 1'b1; rsn = RsnIcmpBig;
        end
      end
    end
  end

  // statistics counters
  logic [COUNTER_BITS-1:0] cnt [NumCounters];
  logic verdict_go;
  assign verdict_go = adv && jb.vld && !jb.is_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumCounters; i++) cnt[i] <= '0;
    end else if (verdict_go) begin
      cnt[CntTotal] <= cnt[CntTotal] + 1'b1;
      if (drop) cnt[CntDrop] <= cnt[CntDrop] + 1'b1;
      else      cnt[CntPass] <= cnt[CntPass] + 1'b1;
      if (bump_syn)  cnt[CntSyn]  <= cnt[CntSyn] + 1'b1;
      if (bump_udp)  cnt[CntUdp]  <= cnt[CntUdp] + 1'b1;
      if (bump_icmp) cnt[CntIcmp] <= cnt[CntIcmp] + 1'b1;
    end
  end

  // a read behind a frame in the pipe must see that frame's bumps
  logic [COUNTER_BITS-1:0] rd_val;
  logic [47:0]             rd_val48;
  always_comb begin
    rd_val = '0;
    if (jb.sel < 3'(NumCounters)) rd_val = cnt[jb.sel];
    rd_val48 = 48'(rd_val);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= jb.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && jb.vld) begin
      out_ch.result_kind   <= jb.is_rd;
      out_ch.verdict       <= jb.is_rd ? 1'b0 : drop;
      out_ch.reason        <= jb.is_rd ? RsnShort : rsn;
      out_ch.counter_value <= jb.is_rd ? rd_val48 : 48'd0;
    end
  end

`ifndef SYNTH
  a_total_split: assert property (@(posedge clk) disable iff (rst)
    verdict_go |=> (cnt[CntTotal] - $past(cnt[CntTotal])) == COUNTER_BITS'(1))
    else $error("total counter did not step once per verdict");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");
  a_read_no_verdict: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind |-> !out_ch.verdict && out_ch.reason == RsnShort)
    else $error("counter read carries verdict bits");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !verdict_go |=> $stable(cnt[CntTotal]))
    else $error("counter moved without a verdict");
`endif
endmodule
